// ===== sv/mxh_pkg.sv =====
// ---------------------------------------------------------------------------
// mxh_pkg: shared constants and helpers for the MP3 Xing header parser
// Tag words, table size, divider widths and the sample rate lookup.
// ---------------------------------------------------------------------------
package mxh_pkg;

   localparam logic [31:0] TAG_XING = 32'h5869_6E67;
   localparam logic [31:0] TAG_INFO = 32'h496E_666F;
   localparam int TOC_LEN = 100;
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // sample rate in Hz from version bits and rate index
   function automatic logic [31:0] rate_hz(input logic [1:0] ver, input logic [1:0] ridx);
      logic [31:0] hz;
      begin
         hz = 32'd44100;
         if (ver == 2'd3) begin
            case (ridx)
               2'd0:    hz = 32'd44100;
               2'd1:    hz = 32'd48000;
               default: hz = 32'd32000;
            endcase
         end else if (ver == 2'd2) begin
            case (ridx)
               2'd0:    hz = 32'd22050;
               2'd1:    hz = 32'd24000;
               default: hz = 32'd16000;
            endcase
         end else begin
            case (ridx)
               2'd0:    hz = 32'd11025;
               2'd1:    hz = 32'd12000;
               default: hz = 32'd8000;
            endcase
         end
         return hz;
      end
   endfunction

endpackage

// ===== sv/mxh_div.sv =====
// ---------------------------------------------------------------------------
// mxh_div: restoring divider, one quotient bit per cycle
// 64-bit dividend over 32-bit divisor; done pulses when the last quotient bit is in.
// ---------------------------------------------------------------------------
module mxh_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [63:0] quo
);
   import mxh_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   // one restoring step
   always_comb begin
      shifted = {rem_ff[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (shifted - {1'b0, den_ff}) : shifted;
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

// ===== sv/mp3_xing_header_parse_seek.sv =====
// ---------------------------------------------------------------------------
// mp3_xing_header_parse_seek: Xing/Info VBR tag parser with seek calculator
// Parses one layer III frame span byte by byte and answers seek requests.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries requests. tuser 0 = one frame byte (tdata[7:0], tlast marks
//   the final byte of the span); tuser 1 = seek request (target, byte range,
//   duration in tdata). rsp_* carries one answer per final byte or seek.
//   Frame bytes that are not last are taken at one per cycle while the
//   sequencer is idle, no answer. A final byte without a frame count goes
//   through the report and output steps; with a frame count the duration
//   goes through the shared multiplier and the bit-serial divider. A seek
//   request runs linearly (multiply, then divide), through the seek table
//   (divide, two table reads, multiply) or straight to output when
//   degenerate. req_tready is low while an answer is being worked out.
//   The answer sits in an output register; while the receiver stalls, frame
//   bytes still flow, but the next answer waits in the sequencer until the
//   register is free. Reset clears the span state and marks the table
//   unusable, so seeks are linear until a span with a good table ends.
// ---------------------------------------------------------------------------
module mp3_xing_header_parse_seek (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_byte[7:0], target_ms[39:8], seek_audio_bytes[71:40],
   // seek_duration_ms[103:72]
   input  logic [103:0] req_tdata,
   input  logic         req_tlast,     // frame_last
   input  logic         req_tuser,     // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // has_vbr_info[0], has_seek_toc[1], total_frames[33:2], audio_bytes[65:34],
   // duration_ms[97:66], seek_offset[129:98], zero[135:130]
   output logic [135:0] rsp_tdata,
   output logic         rsp_tuser      // answer_kind
);
   import mxh_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RPT  = 4'd1;
   localparam logic [3:0] S_MUL  = 4'd2;
   localparam logic [3:0] S_POST = 4'd3;
   localparam logic [3:0] S_DIV  = 4'd4;
   localparam logic [3:0] S_RD0  = 4'd5;
   localparam logic [3:0] S_RD1  = 4'd6;
   localparam logic [3:0] S_PCT  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   localparam logic [1:0] OP_DUR = 2'd0;
   localparam logic [1:0] OP_LIN = 2'd1;
   localparam logic [1:0] OP_TOC = 2'd2;

   // span state
   logic [7:0]  count_ff;
   logic [23:0] header_ff;
   logic        sync_ff, tag_ff, ordered_ff, usable_ff;
   logic [2:0]  flags_ff;
   logic [31:0] shift_ff, frames_ff, bytes_ff;
   logic [7:0]  prev_ff;
   logic [7:0]  toc_mem [TOC_LEN];

   // sequencer
   logic [3:0]  state_ff;
   logic [1:0]  op_ff;
   logic [8:0]  len_ff;
   logic [31:0] mul_a_ff, mul_b_ff, den_ff, range_ff;
   logic [63:0] prod_ff;
   logic [6:0]  i0_ff, rd_addr;
   logic [7:0]  frac_ff, lo_ff, rd_ff;
   logic        res_vbr_ff, res_toc_ff, res_kind_ff;
   logic [31:0] res_frames_ff, res_bytes_ff, res_dur_ff, res_off_ff;
   logic        rsp_valid_ff;
   logic [135:0] rsp_data_ff;
   logic        rsp_kind_ff;

   logic        div_start, div_done;
   logic [63:0] div_num, div_quo;
   logic [31:0] div_den;

   // request fields
   logic        take;
   logic [7:0]  in_byte;
   logic [31:0] in_target, in_range, in_dur;

   // header decode
   logic [7:0]  b1;
   logic [1:0]  ver;
   logic        hdr_ok, mono;
   logic [7:0]  off, frames_at, bytes_at, table_at;

   // byte parse next values
   logic [31:0] shift_in;
   logic        mem_we;
   logic [6:0]  wr_idx;
   logic [7:0]  pos;

   // report
   logic        rpt_vbr, rpt_toc;
   logic [14:0] p100;
   logic [8:0]  next_v, step_v;
   logic [17:0] pct;
   logic [47:0] toc_off;

   assign take      = req_tvalid && req_tready;
   assign in_byte   = req_tdata[7:0];
   assign in_target = req_tdata[39:8];
   assign in_range  = req_tdata[71:40];
   assign in_dur    = req_tdata[103:72];
   assign req_tready = (state_ff == S_IDLE);
   assign pos        = count_ff;

   // header fields and tag layout
   always_comb begin
      b1     = header_ff[23:16];
      ver    = header_ff[20:19];
      mono   = (header_ff[7:6] == 2'd3);
      hdr_ok = sync_ff && (b1[7:5] == 3'b111) && (ver != 2'd1) &&
               (b1[2:1] == 2'd1) && (header_ff[11:10] != 2'd3);
      off    = 8'd4 + (b1[0] ? 8'd0 : 8'd2) +
               ((ver == 2'd3) ? (mono ? 8'd17 : 8'd32) : (mono ? 8'd9 : 8'd17));
      frames_at = off + 8'd8;
      bytes_at  = frames_at + (flags_ff[0] ? 8'd4 : 8'd0);
      table_at  = bytes_at + (flags_ff[1] ? 8'd4 : 8'd0);
      shift_in  = {shift_ff[23:0], in_byte};
      mem_we    = 1'b0;
      wr_idx    = 7'(pos - table_at);
      if (pos >= 8'd4 && hdr_ok && tag_ff && pos >= frames_at && flags_ff[2] &&
          pos >= table_at && pos < table_at + 8'(TOC_LEN)) begin
         mem_we = 1'b1;
      end
   end

   // report flags from the finished span
   always_comb begin
      rpt_vbr = (len_ff >= 9'd4) && hdr_ok && tag_ff && (len_ff >= {1'b0, off} + 9'd8);
      rpt_toc = rpt_vbr && flags_ff[2] && (len_ff >= {1'b0, table_at} + 9'(TOC_LEN)) &&
                (bytes_ff != 32'd0) && ordered_ff;
   end

   // table interpolation pieces
   always_comb begin
      p100    = 15'(div_quo[7:0]) * 15'd100;
      next_v  = (i0_ff < 7'(TOC_LEN - 1)) ? {1'b0, rd_ff} : 9'd256;
      step_v  = (next_v >= {1'b0, lo_ff}) ? (next_v - {1'b0, lo_ff}) : 9'd0;
      pct     = {2'b0, lo_ff, 8'd0} + 18'(step_v * frac_ff);
      toc_off = prod_ff[63:16];
   end

   // table read address
   always_comb begin
      rd_addr = i0_ff;
      if (state_ff == S_RD1) rd_addr = (i0_ff < 7'(TOC_LEN - 1)) ? i0_ff + 7'd1 : i0_ff;
   end

   // seek table memory
   always_ff @(posedge clock) begin
      if (take && !req_tuser && mem_we) toc_mem[wr_idx] <= in_byte;
      rd_ff <= toc_mem[rd_addr];
   end

   // divider operands; a table seek starts dividing on the request itself
   always_comb begin
      div_start = 1'b0;
      div_num   = prod_ff;
      div_den   = den_ff;
      if (take && req_tuser && in_target != 32'd0 && in_dur != 32'd0 &&
          in_range != 32'd0 && in_target < in_dur && usable_ff) begin
         div_start = 1'b1;
         div_num   = {24'd0, in_target, 8'd0};
         div_den   = in_dur;
      end else if (state_ff == S_POST && op_ff != OP_TOC) begin
         div_start = 1'b1;
      end
   end

   mxh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // span parsing and report clear
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         header_ff  <= '0;
         sync_ff    <= 1'b0;
         tag_ff     <= 1'b0;
         flags_ff   <= '0;
         shift_ff   <= '0;
         frames_ff  <= '0;
         bytes_ff   <= '0;
         ordered_ff <= 1'b1;
         usable_ff  <= 1'b0;
      end else if (state_ff == S_RPT) begin
         usable_ff  <= rpt_toc;
         count_ff   <= '0;
         header_ff  <= '0;
         sync_ff    <= 1'b0;
         tag_ff     <= 1'b0;
         flags_ff   <= '0;
         shift_ff   <= '0;
         frames_ff  <= '0;
         bytes_ff   <= '0;
         ordered_ff <= 1'b1;
      end else if (take && !req_tuser) begin
         if (count_ff != 8'd255) count_ff <= count_ff + 8'd1;
         if (pos == 8'd0) begin
            sync_ff   <= (in_byte == 8'hFF);
            usable_ff <= 1'b0;
         end
         if (pos < 8'd4) begin
            header_ff <= {header_ff[15:0], in_byte};
         end else if (hdr_ok && pos >= off) begin
            shift_ff <= shift_in;
            if (pos == off + 8'd3) begin
               tag_ff <= (shift_in == TAG_XING) || (shift_in == TAG_INFO);
            end else if (tag_ff && pos == off + 8'd7) begin
               flags_ff <= shift_in[2:0];
            end else if (tag_ff && pos >= frames_at) begin
               if (flags_ff[0] && pos == frames_at + 8'd3) frames_ff <= shift_in;
               if (flags_ff[1] && pos == bytes_at + 8'd3) bytes_ff <= shift_in;
               if (mem_we) begin
                  prev_ff <= in_byte;
                  if (wr_idx != 7'd0 && in_byte < prev_ff) ordered_ff <= 1'b0;
               end
            end
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (take && req_tuser) begin
                  if (in_target == 32'd0 || in_dur == 32'd0 || in_range == 32'd0 ||
                      in_target >= in_dur) state_ff <= S_OUT;
                  else if (usable_ff) state_ff <= S_DIV;
                  else state_ff <= S_MUL;
               end else if (take && req_tlast) begin
                  state_ff <= S_RPT;
               end
            end
            S_RPT:  state_ff <= (rpt_vbr && frames_ff != 32'd0) ? S_MUL : S_OUT;
            S_MUL:  state_ff <= S_POST;
            S_POST: state_ff <= (op_ff == OP_TOC) ? S_OUT : S_DIV;
            S_DIV: begin
               if (div_done) state_ff <= (op_ff == OP_TOC) ? S_RD0 : S_OUT;
            end
            S_RD0:  state_ff <= S_RD1;
            S_RD1:  state_ff <= S_PCT;
            S_PCT:  state_ff <= S_MUL;
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a_ff * mul_b_ff;
      if (take) len_ff <= {1'b0, pos} + 9'd1;
      if (take && req_tuser) begin
         res_kind_ff   <= 1'b1;
         res_vbr_ff    <= 1'b0;
         res_toc_ff    <= 1'b0;
         res_frames_ff <= '0;
         res_bytes_ff  <= '0;
         res_dur_ff    <= '0;
         range_ff      <= in_range;
         den_ff        <= in_dur;
         mul_a_ff      <= in_range;
         mul_b_ff      <= in_target;
         op_ff         <= usable_ff ? OP_TOC : OP_LIN;
         if (in_target == 32'd0 || in_dur == 32'd0 || in_range == 32'd0) res_off_ff <= '0;
         else res_off_ff <= in_range;
      end
      if (state_ff == S_RPT) begin
         res_kind_ff   <= 1'b0;
         res_vbr_ff    <= rpt_vbr;
         res_toc_ff    <= rpt_toc;
         res_frames_ff <= rpt_vbr ? frames_ff : 32'd0;
         res_bytes_ff  <= rpt_vbr ? bytes_ff : 32'd0;
         res_dur_ff    <= '0;
         res_off_ff    <= '0;
         op_ff         <= OP_DUR;
         mul_a_ff      <= frames_ff;
         mul_b_ff      <= (ver == 2'd3) ? 32'd1152000 : 32'd576000;
         den_ff        <= rate_hz(ver, header_ff[11:10]);
      end
      if (state_ff == S_POST && op_ff == OP_TOC) begin
         res_off_ff <= (toc_off > {16'd0, range_ff}) ? range_ff : toc_off[31:0];
      end
      if (state_ff == S_DIV && div_done) begin
         if (op_ff == OP_DUR) res_dur_ff <= (div_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                                       : div_quo[31:0];
         if (op_ff == OP_LIN) res_off_ff <= div_quo[31:0];
         i0_ff   <= p100[14:8];
         frac_ff <= p100[7:0];
      end
      if (state_ff == S_RD1) lo_ff <= rd_ff;
      if (state_ff == S_PCT) begin
         mul_a_ff <= {14'd0, pct};
         mul_b_ff <= range_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_data_ff <= {6'd0, res_off_ff, res_dur_ff, res_bytes_ff, res_frames_ff,
                         res_toc_ff, res_vbr_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // checks
   a_last_to_rpt: assert property (@(posedge clock) disable iff (reset)
      take && !req_tuser && req_tlast |=> state_ff == S_RPT)
      else $error("final byte did not start a report");

   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("answer loaded outside the output step");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      take && !req_tuser && mem_we |-> wr_idx < 7'(TOC_LEN))
      else $error("seek table write out of range");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

endmodule

// ===== test/tb_mp3_xing_header_parse_seek.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_mp3_xing_header_parse_seek: self-checking bench for the Xing/Info parser
// Streams layer III frame spans and seek requests into the parser, predicts
// every answer with a behavioral model of the tag parser and seek calculator,
// and compares the answers field by field under random bursts and stalls.
// ---------------------------------------------------------------------------
module tb_mp3_xing_header_parse_seek;
   import mxh_pkg::*;

   localparam logic FUNC_BYTE   = 1'b0;
   localparam logic FUNC_SEEK   = 1'b1;
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_SEEK   = 1'b1;
   localparam int   IDLE_LIMIT  = 4000;
   localparam int   ITEM_GOAL   = 1400;
   localparam int   ANSWER_GOAL = 60;

   typedef struct {
      logic        func;
      logic [7:0]  fbyte;
      logic        last;
      logic [31:0] target;
      logic [31:0] range;
      logic [31:0] dur;
   } request_type;

   typedef struct {
      logic        kind;
      logic        vbr;
      logic        toc;
      logic [31:0] frames;
      logic [31:0] abytes;
      logic [31:0] dur;
      logic [31:0] offset;
   } answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;   // frame_byte, target_ms, seek_audio_bytes, seek_duration_ms
   logic         req_tlast = 1'b0; // frame_last
   logic         req_tuser = 1'b0; // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;        // has_vbr_info, has_seek_toc, total_frames, audio_bytes,
                                   // duration_ms, seek_offset, zero fill
   logic         rsp_tuser;        // answer_kind

   request_type pending_reqs[$];
   answer_type  exp_answers[$];
   int          fail_count = 0;
   int          idle_cycles = 0;
   int          n_items = 0;
   int          n_answers = 0;

   always #2 clock = ~clock;

   mp3_xing_header_parse_seek u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // -----------------------------------------------------------------------
   // parser model state
   // -----------------------------------------------------------------------
   logic [7:0]  pos_cnt;
   logic [23:0] hdr_word;
   logic        sync_ok;
   logic        tag_seen;
   logic [2:0]  flags_held;
   logic [31:0] shift_word;
   logic [31:0] frames_held;
   logic [31:0] bytes_held;
   logic [7:0]  toc_mem [TOC_LEN];
   logic        toc_ordered;
   logic        toc_usable;

   function automatic void clear_span();
      pos_cnt = '0; hdr_word = '0; sync_ok = 1'b0; tag_seen = 1'b0;
      flags_held = '0; shift_word = '0; frames_held = '0; bytes_held = '0;
      toc_ordered = 1'b1;
   endfunction

   function automatic logic hdr_ok();
      logic [7:0] b1;
      b1 = hdr_word[23:16];
      return sync_ok && b1[7:5] == 3'b111 && hdr_word[20:19] != 2'd1 &&
             b1[2:1] == 2'd1 && hdr_word[11:10] != 2'd3;
   endfunction

   // position of the tag word: header, optional CRC, side information
   function automatic int tag_pos();
      int  off;
      logic mono;
      mono = hdr_word[7:6] == 2'd3;
      off = 4;
      if (!hdr_word[16]) off += 2;
      if (hdr_word[20:19] == 2'd3) off += mono ? 17 : 32;
      else off += mono ? 9 : 17;
      return off;
   endfunction

   function automatic int toc_pos(int off);
      return off + 8 + (flags_held[0] ? 4 : 0) + (flags_held[1] ? 4 : 0);
   endfunction

   function automatic void absorb_byte(int pos, logic [7:0] b);
      int off, t;
      if (pos == 0) begin
         sync_ok = (b == 8'hFF);
         toc_usable = 1'b0;
      end
      if (pos < 4) begin
         hdr_word = {hdr_word[15:0], b};
         return;
      end
      if (!hdr_ok()) return;
      off = tag_pos();
      if (pos < off) return;
      shift_word = {shift_word[23:0], b};
      if (pos == off + 3) begin
         tag_seen = (shift_word == TAG_XING || shift_word == TAG_INFO);
         return;
      end
      if (!tag_seen || pos < off + 4) return;
      if (pos == off + 7) begin
         flags_held = shift_word[2:0];
         return;
      end
      if (pos < off + 8) return;
      if (flags_held[0] && pos == off + 11) frames_held = shift_word;
      if (flags_held[1] && pos == off + 8 + (flags_held[0] ? 4 : 0) + 3)
         bytes_held = shift_word;
      if (flags_held[2]) begin
         t = toc_pos(off);
         if (pos >= t && pos < t + TOC_LEN) begin
            toc_mem[pos - t] = b;
            if (pos > t && b < toc_mem[pos - t - 1]) toc_ordered = 1'b0;
         end
      end
   endfunction

   function automatic answer_type span_report(int len);
      answer_type a;
      int off;
      logic [63:0] spf, ms;
      a = '{KIND_REPORT, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
      if (len < 4 || !hdr_ok()) return a;
      off = tag_pos();
      if (!tag_seen || len < off + 8) return a;
      a.vbr = 1'b1;
      toc_usable = flags_held[2] && len >= toc_pos(off) + TOC_LEN &&
                   bytes_held != 0 && toc_ordered;
      a.toc = toc_usable;
      a.frames = frames_held;
      a.abytes = bytes_held;
      if (frames_held != 0) begin
         spf = (hdr_word[20:19] == 2'd3) ? 64'd1152 : 64'd576;
         ms = 64'(frames_held) * spf * 64'd1000 / 64'(rate_hz(hdr_word[20:19], hdr_word[11:10]));
         a.dur = (ms > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ms[31:0];
      end
      return a;
   endfunction

   function automatic logic [31:0] seek_offset(logic [31:0] tgt, logic [31:0] rng,
                                               logic [31:0] dur);
      logic [63:0] f256, i0, frac, lo, nxt, stp, pct, off;
      if (tgt == 0 || dur == 0 || rng == 0) return 32'd0;
      if (tgt >= dur) return rng;
      if (!toc_usable) return 32'((64'(rng) * 64'(tgt)) / 64'(dur));
      f256 = 64'(tgt) * 64'd256 / 64'(dur);
      i0 = f256 * 64'd100 / 64'd256;
      if (i0 > 99) i0 = 99;
      frac = f256 * 64'd100 - i0 * 64'd256;
      lo = 64'(toc_mem[i0]);
      nxt = (i0 < 99) ? 64'(toc_mem[i0 + 1]) : 64'd256;
      stp = (nxt >= lo) ? nxt - lo : 64'd0;
      pct = lo * 64'd256 + stp * frac;
      off = pct * 64'(rng) / 64'd65536;
      return (off <= 64'(rng)) ? off[31:0] : rng;
   endfunction

   // advance the model by one accepted request; true when it answers
   function automatic logic predict_request(request_type r, output answer_type a);
      int pos;
      a = '{KIND_SEEK, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
      if (r.func == FUNC_SEEK) begin
         a.offset = seek_offset(r.target, r.range, r.dur);
         return 1'b1;
      end
      pos = pos_cnt;
      absorb_byte(pos, r.fbyte);
      if (pos_cnt != 8'd255) pos_cnt++;
      if (r.last) begin
         a = span_report(pos + 1);
         clear_span();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // -----------------------------------------------------------------------
   // stimulus builders
   // -----------------------------------------------------------------------
   task automatic push_byte(logic [7:0] b, logic last);
      pending_reqs.push_back('{FUNC_BYTE, b, last, $urandom, $urandom, $urandom});
      n_items++;
      if (last) n_answers++;
   endtask

   task automatic push_seek(logic [31:0] tgt, logic [31:0] rng, logic [31:0] dur);
      pending_reqs.push_back('{FUNC_SEEK, 8'($urandom), 1'($urandom), tgt, rng, dur});
      n_items++;
      n_answers++;
   endtask

   task automatic push_span(logic [7:0] s[$]);
      foreach (s[i]) push_byte(s[i], i == s.size() - 1);
   endtask

   // well-formed span: header, side info, tag, fields, table, trailer;
   // cut to max_len bytes when max_len is shorter
   task automatic build_span(logic [1:0] ver, logic prot, logic [1:0] ridx,
                             logic [1:0] mode, logic use_info, logic [2:0] flg,
                             logic [31:0] frames, logic [31:0] abytes,
                             logic ordered, int trailer, int max_len);
      logic [7:0]  s[$];
      logic [31:0] tag, fw;
      logic [7:0]  v;
      int          off;
      s.push_back(8'hFF);
      s.push_back({3'b111, ver, 2'b01, prot});
      s.push_back({4'($urandom), ridx, 2'($urandom)});
      s.push_back({mode, 6'($urandom)});
      off = 4 + (prot ? 0 : 2) + ((ver == 2'd3) ? ((mode == 2'd3) ? 17 : 32)
                                                 : ((mode == 2'd3) ? 9 : 17));
      while (s.size() < off) s.push_back(8'($urandom));
      tag = use_info ? TAG_INFO : TAG_XING;
      fw = {29'($urandom_range(0, 3) == 0 ? $urandom : 0), flg};
      for (int k = 3; k >= 0; k--) s.push_back(tag[8*k +: 8]);
      for (int k = 3; k >= 0; k--) s.push_back(fw[8*k +: 8]);
      if (flg[0]) for (int k = 3; k >= 0; k--) s.push_back(frames[8*k +: 8]);
      if (flg[1]) for (int k = 3; k >= 0; k--) s.push_back(abytes[8*k +: 8]);
      if (flg[2]) begin
         v = 8'($urandom_range(0, 20));
         for (int k = 0; k < TOC_LEN; k++) begin
            s.push_back(ordered ? v : 8'($urandom));
            if (v < 8'd253) v += 8'($urandom_range(0, 3));
         end
      end
      repeat (trailer) s.push_back(8'($urandom));
      while (s.size() > max_len && s.size() > 1) void'(s.pop_back());
      push_span(s);
   endtask

   task automatic random_span();
      logic [1:0] ver;
      logic [2:0] flg;
      int         cut, pick;
      pick = $urandom_range(0, 2);
      ver = (pick == 0) ? 2'd0 : (pick == 1) ? 2'd2 : 2'd3;
      // mostly short spans without a table keep answers frequent
      flg = 3'($urandom);
      if ($urandom_range(0, 2) != 0) flg[2] = 1'b0;
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : 1000;
      build_span(ver, 1'($urandom), 2'($urandom_range(0, 2)), 2'($urandom),
                 1'($urandom), flg,
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20000),
                 ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom,
                 $urandom_range(0, 4) != 0, $urandom_range(0, 6), cut);
   endtask

   task automatic noise_span();
      logic [7:0] s[$];
      int n;
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) s.push_back(8'($urandom));
      if ($urandom_range(0, 1)) s[0] = 8'hFF;
      if (n > 1 && $urandom_range(0, 1)) s[1] = s[1] | 8'hE0;
      push_span(s);
   endtask

   task automatic random_seek();
      logic [31:0] d, t, r;
      d = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 400000);
      r = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 1 << 20);
      t = (d > 1) ? 32'($urandom_range(1, d - 1)) : $urandom;
      case ($urandom_range(0, 9))
         0:       t = 32'd0;
         1:       t = d + 32'($urandom_range(0, 5));
         2:       d = 32'd0;
         3:       r = 32'd0;
         default: ;
      endcase
      push_seek(t, r, d);
   endtask

   // -----------------------------------------------------------------------
   // request list: directed part, then random spans and seeks
   // -----------------------------------------------------------------------
   initial begin
      logic [7:0] s[$];
      // spans too short for a header, and a broken sync
      s = '{8'hFF, 8'hFB, 8'h90}; push_span(s);
      s = '{8'hFE, 8'hFB, 8'h90, 8'h00, 8'h00}; push_span(s);
      // reserved version, wrong layer, reserved rate
      s = '{8'hFF, 8'hEB, 8'h90, 8'h00, 8'h11}; push_span(s);
      s = '{8'hFF, 8'hFD, 8'h90, 8'h00, 8'h11}; push_span(s);
      s = '{8'hFF, 8'hFB, 8'h9C, 8'h00, 8'h11}; push_span(s);
      // degenerate and linear seeks with no table
      push_seek(32'd0, 32'd1000, 32'd500);
      push_seek(32'd10, 32'd1000, 32'd0);
      push_seek(32'd10, 32'd0, 32'd500);
      push_seek(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_seek(32'd250, 32'hFFFF_FFFF, 32'd500);
      // full Xing span with every field and a good table, then table seeks
      build_span(2'd3, 1'b1, 2'd0, 2'd0, 1'b0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b1, 2, 1000);
      push_seek(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_seek(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_seek(32'd123456, 32'd9000000, 32'd260000);
      // Info span, mono MPEG-2, with CRC and an unordered table
      build_span(2'd2, 1'b0, 2'd1, 2'd3, 1'b1, 3'd6, 32'd0, 32'd77777, 1'b0, 0, 1000);
      push_seek(32'd100, 32'd5000, 32'd400);
      // MPEG-2.5 mono span with frame and byte counts and no table
      build_span(2'd0, 1'b1, 2'd2, 2'd3, 1'b0, 3'd3, 32'd1, 32'd99, 1'b1, 0, 31);
      // span longer than the position counter with a usable table
      build_span(2'd3, 1'b0, 2'd2, 2'd1, 1'b0, 3'd7, 32'd5000, 32'd400000,
                 1'b1, 140, 1000);
      // seek arriving inside a span falls back to the linear formula
      push_byte(8'hFF, 1'b0);
      push_seek(32'd1000, 32'd400000, 32'd3000);
      s = '{8'hFB, 8'h90, 8'h00}; push_span(s);

      while (n_items < ITEM_GOAL || n_answers < ANSWER_GOAL) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: random_seek();
            4:          noise_span();
            default:    random_span();
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // reset
   // -----------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // -----------------------------------------------------------------------
   // request driver: bursts of random length separated by random gaps
   // -----------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_tdata  <= {r.dur, r.range, r.target, r.fbyte};
            req_tlast  <= r.last;
            req_tuser  <= r.func;
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // -----------------------------------------------------------------------
   // answer stall pattern: always ready, coin flip, or one cycle in eight
   // -----------------------------------------------------------------------
   int stall_phase = 0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 300) % 3)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom);
         default: rsp_tready <= (stall_phase % 8) == 3;
      endcase
   end

   // -----------------------------------------------------------------------
   // answer checker, then model update for the request taken this edge
   // -----------------------------------------------------------------------
   initial begin
      clear_span();
      toc_usable = 1'b0;
      foreach (toc_mem[i]) toc_mem[i] = '0;
   end

   always @(posedge clock) begin
      answer_type  want, got;
      request_type r;
      logic        moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got = '{rsp_tuser, rsp_tdata[0], rsp_tdata[1], rsp_tdata[33:2],
                    rsp_tdata[65:34], rsp_tdata[97:66], rsp_tdata[129:98]};
            if (exp_answers.size() == 0) begin
               $error("unexpected answer, kind %0d", got.kind);
               fail_count++;
            end else begin
               want = exp_answers.pop_front();
               if (got.kind !== want.kind) begin
                  $error("answer_kind: expected %0d, got %0d", want.kind, got.kind);
                  fail_count++;
               end
               if (got.vbr !== want.vbr) begin
                  $error("has_vbr_info: expected %0d, got %0d", want.vbr, got.vbr);
                  fail_count++;
               end
               if (got.toc !== want.toc) begin
                  $error("has_seek_toc: expected %0d, got %0d", want.toc, got.toc);
                  fail_count++;
               end
               if (got.frames !== want.frames) begin
                  $error("total_frames: expected %0d, got %0d", want.frames, got.frames);
                  fail_count++;
               end
               if (got.abytes !== want.abytes) begin
                  $error("audio_bytes: expected %0d, got %0d", want.abytes, got.abytes);
                  fail_count++;
               end
               if (got.dur !== want.dur) begin
                  $error("duration_ms: expected %0d, got %0d", want.dur, got.dur);
                  fail_count++;
               end
               if (got.offset !== want.offset) begin
                  $error("seek_offset: expected %0d, got %0d", want.offset, got.offset);
                  fail_count++;
               end
               if (rsp_tdata[135:130] !== 6'd0) begin
                  $error("zero fill: expected 0, got %0h", rsp_tdata[135:130]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            r = '{req_tuser, req_tdata[7:0], req_tlast, req_tdata[39:8],
                  req_tdata[71:40], req_tdata[103:72]};
            if (predict_request(r, want)) exp_answers.push_back(want);
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // -----------------------------------------------------------------------
   // end of run and watchdog
   // -----------------------------------------------------------------------
   initial begin
      @(negedge reset);
      while (pending_reqs.size() > 0 || req_tvalid || exp_answers.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("mp3_xing_header_parse_seek test passed");
      end else begin
         $display("mp3_xing_header_parse_seek test failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("mp3_xing_header_parse_seek test failed");
         $finish;
      end
   end

endmodule
